### design/cfe_pkg.sv
// Package for the continued fraction expander: datapath widths, result cap
// and the sequencer state type. No dependencies.
package cfe_pkg;

  localparam int FIELD_W     = 32;                      // width of the item fields
  localparam int WORD_W      = 32;                      // divider datapath width
  localparam int MAX_RESULTS = 48;                      // cap on quotients emitted per item
  localparam int SHIFT_W     = $clog2(WORD_W);          // divisor alignment count
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1); // emitted-result count

  typedef enum logic [1:0] {
    S_IDLE,
    S_ALIGN,
    S_DIV,
    S_OUT
  } cfe_state_t;

endpackage

### design/cfe_if.sv
// Valid/ready channel interfaces for the continued fraction expander.
// Depends on cfe_pkg for the field width.
interface cfe_in_if;
  logic                       valid;
  logic                       ready;
  logic [cfe_pkg::FIELD_W-1:0] numerator;
  logic [cfe_pkg::FIELD_W-1:0] denominator;

  modport source (output valid, output numerator, output denominator, input ready);
  modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface cfe_out_if;
  logic                       valid;
  logic                       ready;
  logic [cfe_pkg::FIELD_W-1:0] quotient;
  logic                       quotient_valid;
  logic [cfe_pkg::FIELD_W-1:0] common_divisor;
  logic                       last;

  modport source (output valid, output quotient, output quotient_valid,
                  output common_divisor, output last, input ready);
  modport sink   (input valid, input quotient, input quotient_valid,
                  input common_divisor, input last, output ready);
endinterface

### design/continued_fraction_expander_unit.sv
// Continued fraction expander top level: Euclid run on a shift-subtract divider.
// Depends on cfe_pkg and the channel interfaces in cfe_if.sv.
//
//   channel  | dir | payload                                          | handshake
//   in_chan  | in  | numerator, denominator                           | valid/ready
//   out_chan | out | quotient, quotient_valid, common_divisor, last   | valid/ready
//
// One item at a time. For each partial quotient q the divisor is doubled one
// bit a cycle until it just fits under the remainder, then one quotient bit is
// produced a cycle while it halves back. Each result then passes through the
// output register, which holds it while out_chan stalls.
// A zero denominator gives its single result in the cycle after the transfer.
// Synchronous active-low reset returns the sequencer to idle; no clearing pass.
module continued_fraction_expander_unit (
  input  logic       clk,
  input  logic       rst_n,
  cfe_in_if.sink     in_chan,
  cfe_out_if.source  out_chan
);

  localparam int W = cfe_pkg::WORD_W;

  cfe_pkg::cfe_state_t state_r, state_nxt;

  logic [W-1:0]                r_r, r_nxt;     // running remainder / dividend
  logic [W-1:0]                d_r, d_nxt;     // shifted divisor
  logic [W-1:0]                q_r, q_nxt;     // quotient shift register
  logic [cfe_pkg::SHIFT_W-1:0] k_r, k_nxt;     // alignment shift count
  logic [cfe_pkg::CNT_W-1:0]   n_r, n_nxt;     // results emitted so far
  logic                        hold_r, hold_nxt;

  logic [cfe_pkg::FIELD_W-1:0] out_q_r, out_q_nxt;
  logic                        out_qv_r, out_qv_nxt;
  logic [cfe_pkg::FIELD_W-1:0] out_g_r, out_g_nxt;
  logic                        out_last_r, out_last_nxt;

  logic         in_xfer, out_xfer;
  logic [W-1:0] a_w, b_w;
  logic [W-1:0] d_dbl;
  logic         can_dbl;
  logic [W:0]   diff;
  logic         fits;
  logic [W-1:0] r_new, q_new;
  logic         div_end, run_last, cap;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_xfer = out_chan.valid && out_chan.ready;
  assign a_w      = W'(in_chan.numerator);
  assign b_w      = W'(in_chan.denominator);

  assign d_dbl    = {d_r[W-2:0], 1'b0};
  assign can_dbl  = !d_r[W-1] && (d_dbl <= r_r);
  assign diff     = {1'b0, r_r} - {1'b0, d_r};
  assign fits     = !diff[W];
  assign r_new    = fits ? diff[W-1:0] : r_r;
  assign q_new    = {q_r[W-2:0], fits};
  assign div_end  = (k_r == '0);
  assign run_last = (r_new == '0);
  assign cap      = (n_r == cfe_pkg::CNT_W'(cfe_pkg::MAX_RESULTS - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cfe_pkg::S_IDLE: begin
        if (in_xfer) begin
          state_nxt = (b_w == '0) ? cfe_pkg::S_OUT : cfe_pkg::S_ALIGN;
        end
      end
      cfe_pkg::S_ALIGN: begin
        if (!can_dbl) begin
          state_nxt = cfe_pkg::S_DIV;
        end
      end
      cfe_pkg::S_DIV: begin
        if (div_end) begin
          if (run_last) begin
            state_nxt = cfe_pkg::S_OUT;
          end else if (hold_r || cap) begin
            state_nxt = cfe_pkg::S_ALIGN;
          end else begin
            state_nxt = cfe_pkg::S_OUT;
          end
        end
      end
      cfe_pkg::S_OUT: begin
        if (out_chan.ready) begin
          state_nxt = out_last_r ? cfe_pkg::S_IDLE : cfe_pkg::S_ALIGN;
        end
      end
      default: state_nxt = cfe_pkg::S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_chan.ready  = (state_r == cfe_pkg::S_IDLE);
    out_chan.valid = (state_r == cfe_pkg::S_OUT);
  end

  assign out_chan.quotient       = out_q_r;
  assign out_chan.quotient_valid = out_qv_r;
  assign out_chan.common_divisor = out_g_r;
  assign out_chan.last           = out_last_r;

  // Datapath
  always_comb begin
    r_nxt        = r_r;
    d_nxt        = d_r;
    q_nxt        = q_r;
    k_nxt        = k_r;
    n_nxt        = n_r;
    hold_nxt     = hold_r;
    out_q_nxt    = out_q_r;
    out_qv_nxt   = out_qv_r;
    out_g_nxt    = out_g_r;
    out_last_nxt = out_last_r;
    case (state_r)
      cfe_pkg::S_IDLE: begin
        if (in_xfer) begin
          r_nxt    = a_w;
          d_nxt    = b_w;
          q_nxt    = '0;
          k_nxt    = '0;
          n_nxt    = '0;
          hold_nxt = 1'b0;
          if (b_w == '0) begin
            out_q_nxt    = '0;
            out_qv_nxt   = 1'b0;
            out_g_nxt    = cfe_pkg::FIELD_W'(a_w);
            out_last_nxt = 1'b1;
          end
        end
      end
      cfe_pkg::S_ALIGN: begin
        if (can_dbl) begin
          d_nxt = d_dbl;
          k_nxt = k_r + 1'b1;
        end
      end
      cfe_pkg::S_DIV: begin
        r_nxt = r_new;
        q_nxt = q_new;
        if (!div_end) begin
          d_nxt = d_r >> 1;
          k_nxt = k_r - 1'b1;
        end else begin
          // advance Euclid: (a, b) <= (b, a mod b); d is back to b here
          r_nxt = d_r;
          d_nxt = r_new;
          q_nxt = '0;
          if (run_last) begin
            if (!hold_r) begin
              out_q_nxt = cfe_pkg::FIELD_W'(q_new);
            end
            out_qv_nxt   = 1'b1;
            out_g_nxt    = cfe_pkg::FIELD_W'(d_r);
            out_last_nxt = 1'b1;
          end else if (!hold_r) begin
            out_q_nxt    = cfe_pkg::FIELD_W'(q_new);
            out_qv_nxt   = 1'b1;
            out_g_nxt    = '0;
            out_last_nxt = 1'b0;
            n_nxt        = n_r + 1'b1;
            // at the cap, keep this quotient back for the final result
            hold_nxt     = cap;
          end
        end
      end
      cfe_pkg::S_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cfe_pkg::S_IDLE;
      hold_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hold_r  <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r        <= r_nxt;
    d_r        <= d_nxt;
    q_r        <= q_nxt;
    k_r        <= k_nxt;
    n_r        <= n_nxt;
    out_q_r    <= out_q_nxt;
    out_qv_r   <= out_qv_nxt;
    out_g_r    <= out_g_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

### design/cfe_checker.sv
// Port-level checks for continued_fraction_expander_unit, attached by bind.
// Depends on cfe_pkg for the field width.
module cfe_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [cfe_pkg::FIELD_W-1:0] in_denominator,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_quotient_valid,
  input logic [cfe_pkg::FIELD_W-1:0] out_common_divisor,
  input logic                        out_last
);

  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("item taken while a result is pending");

  a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_denominator == '0 |=>
      out_valid && !out_quotient_valid && out_last)
    else $error("zero denominator did not give a single flagged result");

  a_mid_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_quotient_valid && out_common_divisor == '0)
    else $error("intermediate result carries gcd or invalid quotient");

  a_ready_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready)
    else $error("not ready after the final result of a run");

endmodule

bind continued_fraction_expander_unit cfe_checker u_cfe_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_chan.valid),
  .in_ready           (in_chan.ready),
  .in_denominator     (in_chan.denominator),
  .out_valid          (out_chan.valid),
  .out_ready          (out_chan.ready),
  .out_quotient_valid (out_chan.quotient_valid),
  .out_common_divisor (out_chan.common_divisor),
  .out_last           (out_chan.last)
);
